// File: rtl/kvt_pkg.sv
// Shared types, codes and character constants of the key/value text tokenizer.
package kvt_pkg;

  localparam int MAX_DEPTH_DEF = 16;
  localparam int LEVEL_W       = 5;
  localparam int MAG_W         = 33;
  localparam int NUM_W         = 32;

  // event codes
  localparam logic [2:0] EV_CONTENT = 3'd0;
  localparam logic [2:0] EV_TOK_END = 3'd1;
  localparam logic [2:0] EV_OPEN    = 3'd2;
  localparam logic [2:0] EV_CLOSE   = 3'd3;
  localparam logic [2:0] EV_ERROR   = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd1;
  localparam logic [2:0] ERR_OPEN_KEY  = 3'd2;
  localparam logic [2:0] ERR_CLOSE_VAL = 3'd3;
  localparam logic [2:0] ERR_NO_LEVEL  = 3'd4;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd5;

  // number reader phases
  localparam logic [2:0] NP_LEAD   = 3'd0;
  localparam logic [2:0] NP_SIGN   = 3'd1;
  localparam logic [2:0] NP_DIGITS = 3'd2;
  localparam logic [2:0] NP_TRAIL  = 3'd3;
  localparam logic [2:0] NP_BAD    = 3'd4;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [MAG_W-1:0] MAG_CAP     = 33'h1_0000_0000;
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = 33'h0_8000_0000;
  localparam logic [MAG_W-1:0] MAG_POS_MAX = 33'h0_7FFF_FFFF;

  typedef struct packed {
    logic [2:0]              event_res;
    logic                    role;
    logic [7:0]              content;
    logic                    is_number;
    logic signed [NUM_W-1:0] number;
    logic [LEVEL_W-1:0]      level;
    logic [2:0]              error_code;
    logic                    last;
  } res_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_CR) ||
           (b == CH_VT) || (b == CH_FF);
  endfunction

  function automatic res_t mk_res(input logic [2:0] ev, input logic role,
                                  input logic [7:0] ch, input logic isn,
                                  input logic [NUM_W-1:0] num,
                                  input logic [LEVEL_W-1:0] lvl,
                                  input logic [2:0] err);
    res_t r;
    r.event_res  = ev;
    r.role       = role;
    r.content    = ch;
    r.is_number  = isn;
    r.number     = num;
    r.level      = lvl;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/keyvalue_text_tokenizer_top.sv
// Top level of the streaming key/value text tokenizer.
// Use: one text byte per request on the in_ channel (in_data_byte, with
// in_restart to clear all parser state before that byte). Each byte gives
// zero, one or two result requests on the out_ channel: content bytes tagged
// key or value, token ends (with a decimal reading for value tokens), group
// open and close, and errors. out_last marks the final result of a byte.
// Results are registered in the result queue and offered on out_ from there.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; bytes with two results fill the queue
// faster than it drains. The rate is set by the single output port of the
// four-entry result queue; in_ready is high while two or more slots are free.
// After an error no results come until a byte arrives with in_restart set.
// Reset: the parser returns to root level expecting a key and the queue
// empties. When the receiver stalls, results wait in the queue and in_ready
// falls once fewer than two slots are free; nothing is dropped.
module keyvalue_text_tokenizer_top #(
  parameter int MAX_DEPTH = kvt_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic        out_role,
  output logic [7:0]  out_content,
  output logic        out_is_number,
  output logic signed [31:0] out_number,
  output logic [4:0]  out_level,
  output logic [2:0]  out_error_code,
  output logic        out_last
);

  kvt_pkg::res_t res0, res1, head;
  logic [1:0]    push_n;
  logic          acc;
  logic          space2;

  assign in_ready = space2;
  assign acc      = in_valid && in_ready;

  kvt_parse #(.MAX_DEPTH(MAX_DEPTH)) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .restart   (in_restart),
    .res0      (res0),
    .res1      (res1),
    .push_n    (push_n)
  );

  kvt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .wr0       (res0),
    .wr1       (res1),
    .space2    (space2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head)
  );

  assign out_event_res  = head.event_res;
  assign out_role       = head.role;
  assign out_content    = head.content;
  assign out_is_number  = head.is_number;
  assign out_number     = head.number;
  assign out_level      = head.level;
  assign out_error_code = head.error_code;
  assign out_last       = head.last;

endmodule

// File: rtl/kvt_parse.sv
// Parser state and per-byte event logic: up to two results per accepted request.
module kvt_parse #(
  parameter int MAX_DEPTH = kvt_pkg::MAX_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          restart,
  output kvt_pkg::res_t res0,
  output kvt_pkg::res_t res1,
  output logic [1:0]    push_n
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
  localparam int LW = kvt_pkg::LEVEL_W;
  localparam int MW = kvt_pkg::MAG_W;

  logic                 expect_key_r, expect_key_nxt;
  logic                 in_quotes_r, in_quotes_nxt;
  logic                 esc_r, esc_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic                 stopped_r, stopped_nxt;
  logic [2:0]           nphase_r, nphase_nxt;
  logic                 nneg_r, nneg_nxt;
  logic [MW-1:0]        nmag_r, nmag_nxt;

  // state seen by this byte (after an optional restart)
  logic                 s_ek, s_iq, s_esc, s_ne, s_stop, s_neg;
  logic [DEPTH_W-1:0]   s_depth;
  logic [2:0]           s_phase;
  logic [MW-1:0]        s_mag;

  // number reader step for a content byte
  logic                 b_digit, b_space;
  logic [3:0]           b_dval;
  logic [MW+3:0]        mag_x10;
  logic [MW-1:0]        mag_sat;
  logic [2:0]           nf_phase;
  logic                 nf_neg;
  logic [MW-1:0]        nf_mag;

  // token end outcome
  logic                 te_fail, te_isn;
  logic [kvt_pkg::NUM_W-1:0] te_num;

  logic [DEPTH_W+LW-1:0] lvl_ext_cur, lvl_ext_up, lvl_ext_dn;
  logic [LW-1:0]        lvl_cur, lvl_up, lvl_dn;

  kvt_pkg::res_t        r0, r1;
  logic [1:0]           cnt;
  logic                 te_ok;

  always_comb begin
    s_ek    = restart ? 1'b1 : expect_key_r;
    s_iq    = restart ? 1'b0 : in_quotes_r;
    s_esc   = restart ? 1'b0 : esc_r;
    s_ne    = restart ? 1'b0 : nonempty_r;
    s_depth = restart ? DEPTH_ONE : depth_r;
    s_stop  = restart ? 1'b0 : stopped_r;
    s_phase = restart ? kvt_pkg::NP_LEAD : nphase_r;
    s_neg   = restart ? 1'b0 : nneg_r;
    s_mag   = restart ? '0 : nmag_r;
  end

  assign lvl_ext_cur = {{LW{1'b0}}, s_depth};
  assign lvl_ext_up  = {{LW{1'b0}}, s_depth + DEPTH_ONE};
  assign lvl_ext_dn  = {{LW{1'b0}}, s_depth - DEPTH_ONE};
  assign lvl_cur     = lvl_ext_cur[LW-1:0];
  assign lvl_up      = lvl_ext_up[LW-1:0];
  assign lvl_dn      = lvl_ext_dn[LW-1:0];

  assign b_digit = (data_byte >= kvt_pkg::CH_ZERO) && (data_byte <= kvt_pkg::CH_NINE);
  assign b_space = kvt_pkg::is_space(data_byte);
  assign b_dval  = data_byte[3:0];
  // times ten as two shifts and an add
  assign mag_x10 = ({4'b0, s_mag} << 3) + ({4'b0, s_mag} << 1) + {{MW{1'b0}}, b_dval};
  assign mag_sat = (mag_x10 > {4'b0, kvt_pkg::MAG_CAP}) ? kvt_pkg::MAG_CAP : mag_x10[MW-1:0];

  always_comb begin
    nf_phase = s_phase;
    nf_neg   = s_neg;
    nf_mag   = s_mag;
    case (s_phase)
      kvt_pkg::NP_LEAD: begin
        if (b_space) begin
          nf_phase = kvt_pkg::NP_LEAD;
        end else if ((data_byte == kvt_pkg::CH_PLUS) || (data_byte == kvt_pkg::CH_MINUS)) begin
          nf_neg   = (data_byte == kvt_pkg::CH_MINUS);
          nf_phase = kvt_pkg::NP_SIGN;
        end else if (b_digit) begin
          nf_phase = kvt_pkg::NP_DIGITS;
          nf_mag   = {{(MW-4){1'b0}}, b_dval};
        end else begin
          nf_phase = kvt_pkg::NP_BAD;
        end
      end
      kvt_pkg::NP_SIGN, kvt_pkg::NP_DIGITS: begin
        if (b_digit) begin
          nf_phase = kvt_pkg::NP_DIGITS;
          nf_mag   = mag_sat;
        end else if ((s_phase == kvt_pkg::NP_DIGITS) && b_space) begin
          nf_phase = kvt_pkg::NP_TRAIL;
        end else begin
          nf_phase = kvt_pkg::NP_BAD;
        end
      end
      kvt_pkg::NP_TRAIL: begin
        if (!b_space) nf_phase = kvt_pkg::NP_BAD;
      end
      default: nf_phase = kvt_pkg::NP_BAD;
    endcase
  end

  always_comb begin
    te_fail = (s_depth == '0);
    te_isn  = 1'b0;
    te_num  = '0;
    if (!s_ek && ((s_phase == kvt_pkg::NP_DIGITS) || (s_phase == kvt_pkg::NP_TRAIL))) begin
      if (s_neg && (s_mag <= kvt_pkg::MAG_NEG_MAX)) begin
        te_isn = 1'b1;
        te_num = 32'(0) - s_mag[kvt_pkg::NUM_W-1:0];
      end else if (!s_neg && (s_mag <= kvt_pkg::MAG_POS_MAX)) begin
        te_isn = 1'b1;
        te_num = s_mag[kvt_pkg::NUM_W-1:0];
      end
    end
  end

  always_comb begin
    expect_key_nxt = s_ek;
    in_quotes_nxt  = s_iq;
    esc_nxt        = s_esc;
    nonempty_nxt   = s_ne;
    depth_nxt      = s_depth;
    stopped_nxt    = s_stop;
    nphase_nxt     = s_phase;
    nneg_nxt       = s_neg;
    nmag_nxt       = s_mag;
    r0  = '0;
    r1  = '0;
    cnt = 2'd0;
    te_ok = 1'b1;

    if (!s_stop) begin
      if (s_esc) begin
        esc_nxt = 1'b0;
        if ((data_byte == kvt_pkg::CH_NL) || (data_byte == kvt_pkg::CH_TAB) ||
            (data_byte == kvt_pkg::CH_CR) || (data_byte == kvt_pkg::CH_BSLASH) ||
            (data_byte == kvt_pkg::CH_QUOTE)) begin
          r0 = kvt_pkg::mk_res(kvt_pkg::EV_CONTENT, !s_ek, data_byte, 1'b0, '0, lvl_cur,
                               kvt_pkg::ERR_NONE);
          nonempty_nxt = 1'b1;
          nphase_nxt = nf_phase; nneg_nxt = nf_neg; nmag_nxt = nf_mag;
        end else begin
          r0 = kvt_pkg::mk_res(kvt_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, '0, lvl_cur,
                               kvt_pkg::ERR_BAD_ESC);
          stopped_nxt = 1'b1;
        end
        cnt = 2'd1;
      end else if (data_byte == kvt_pkg::CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (s_iq && (data_byte != kvt_pkg::CH_QUOTE)) begin
        r0 = kvt_pkg::mk_res(kvt_pkg::EV_CONTENT, !s_ek, data_byte, 1'b0, '0, lvl_cur,
                             kvt_pkg::ERR_NONE);
        nonempty_nxt = 1'b1;
        nphase_nxt = nf_phase; nneg_nxt = nf_neg; nmag_nxt = nf_mag;
        cnt = 2'd1;
      end else if (s_iq || (data_byte == kvt_pkg::CH_SPACE) || (data_byte == kvt_pkg::CH_TAB) ||
                   (data_byte == kvt_pkg::CH_NL) || (data_byte == kvt_pkg::CH_CR) ||
                   (data_byte == kvt_pkg::CH_QUOTE) || (data_byte == kvt_pkg::CH_LBRACE) ||
                   (data_byte == kvt_pkg::CH_RBRACE)) begin
        // closing quote, delimiter or brace: a pending token ends first
        if (s_iq) begin
          in_quotes_nxt = 1'b0;
        end else if ((data_byte != kvt_pkg::CH_LBRACE) && (data_byte != kvt_pkg::CH_RBRACE)) begin
          in_quotes_nxt = (data_byte == kvt_pkg::CH_QUOTE);
        end
        if (s_iq || s_ne) begin
          cnt = 2'd1;
          if (te_fail) begin
            r0 = kvt_pkg::mk_res(kvt_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, '0, lvl_cur,
                                 kvt_pkg::ERR_NO_LEVEL);
            stopped_nxt = 1'b1;
            te_ok = 1'b0;
          end else begin
            r0 = kvt_pkg::mk_res(kvt_pkg::EV_TOK_END, !s_ek, 8'd0, te_isn, te_num, lvl_cur,
                                 kvt_pkg::ERR_NONE);
            expect_key_nxt = !s_ek;
            nonempty_nxt   = 1'b0;
            nphase_nxt     = kvt_pkg::NP_LEAD;
            nneg_nxt       = 1'b0;
            nmag_nxt       = '0;
          end
        end
        if (!s_iq && te_ok &&
            ((data_byte == kvt_pkg::CH_LBRACE) || (data_byte == kvt_pkg::CH_RBRACE))) begin
          if (data_byte == kvt_pkg::CH_LBRACE) begin
            if (expect_key_nxt) begin
              r1 = kvt_pkg::mk_res(kvt_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, '0, lvl_cur,
                                   kvt_pkg::ERR_OPEN_KEY);
              stopped_nxt = 1'b1;
            end else if (s_depth >= DEPTH_MAX) begin
              r1 = kvt_pkg::mk_res(kvt_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, '0, lvl_cur,
                                   kvt_pkg::ERR_TOO_DEEP);
              stopped_nxt = 1'b1;
            end else begin
              r1 = kvt_pkg::mk_res(kvt_pkg::EV_OPEN, 1'b0, 8'd0, 1'b0, '0, lvl_up,
                                   kvt_pkg::ERR_NONE);
              depth_nxt      = s_depth + DEPTH_ONE;
              expect_key_nxt = 1'b1;
            end
          end else begin
            if (!expect_key_nxt) begin
              r1 = kvt_pkg::mk_res(kvt_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, '0, lvl_cur,
                                   kvt_pkg::ERR_CLOSE_VAL);
              stopped_nxt = 1'b1;
            end else if (s_depth == '0) begin
              r1 = kvt_pkg::mk_res(kvt_pkg::EV_ERROR, 1'b0, 8'd0, 1'b0, '0, lvl_cur,
                                   kvt_pkg::ERR_NO_LEVEL);
              stopped_nxt = 1'b1;
            end else begin
              r1 = kvt_pkg::mk_res(kvt_pkg::EV_CLOSE, 1'b0, 8'd0, 1'b0, '0, lvl_dn,
                                   kvt_pkg::ERR_NONE);
              depth_nxt = s_depth - DEPTH_ONE;
            end
          end
          // group event goes behind any token end
          if (cnt == 2'd0) begin
            r0 = r1;
            cnt = 2'd1;
          end else begin
            cnt = 2'd2;
          end
        end
      end else begin
        r0 = kvt_pkg::mk_res(kvt_pkg::EV_CONTENT, !s_ek, data_byte, 1'b0, '0, lvl_cur,
                             kvt_pkg::ERR_NONE);
        nonempty_nxt = 1'b1;
        nphase_nxt = nf_phase; nneg_nxt = nf_neg; nmag_nxt = nf_mag;
        cnt = 2'd1;
      end
    end

    if (cnt == 2'd1) r0.last = 1'b1;
    if (cnt == 2'd2) r1.last = 1'b1;
  end

  assign res0   = r0;
  assign res1   = r1;
  assign push_n = acc ? cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_key_r <= 1'b1;
      in_quotes_r  <= 1'b0;
      esc_r        <= 1'b0;
      nonempty_r   <= 1'b0;
      depth_r      <= DEPTH_ONE;
      stopped_r    <= 1'b0;
      nphase_r     <= kvt_pkg::NP_LEAD;
      nneg_r       <= 1'b0;
      nmag_r       <= '0;
    end else if (acc) begin
      expect_key_r <= expect_key_nxt;
      in_quotes_r  <= in_quotes_nxt;
      esc_r        <= esc_nxt;
      nonempty_r   <= nonempty_nxt;
      depth_r      <= depth_nxt;
      stopped_r    <= stopped_nxt;
      nphase_r     <= nphase_nxt;
      nneg_r       <= nneg_nxt;
      nmag_r       <= nmag_nxt;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_MAX)
    else $error("nesting depth above maximum");

  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && !restart) |-> (push_n == 2'd0))
    else $error("results after an error without restart");

  a_mag_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nmag_r <= kvt_pkg::MAG_CAP)
    else $error("number magnitude above cap");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (push_n != 2'd0) &&
     (((push_n == 2'd1) && (r0.event_res == kvt_pkg::EV_ERROR)) ||
      ((push_n == 2'd2) && (r1.event_res == kvt_pkg::EV_ERROR)))) |=> stopped_r)
    else $error("error event did not stop the parser");

endmodule

// File: rtl/kvt_outq.sv
// Four-entry result queue: takes up to two results a cycle, hands out one.
module kvt_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  kvt_pkg::res_t wr0,
  input  kvt_pkg::res_t wr1,
  output logic          space2,
  output logic          out_valid,
  input  logic          out_ready,
  output kvt_pkg::res_t out_res
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  kvt_pkg::res_t      mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic               pop;
  logic [PTR_W-1:0]   wp1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign space2    = (cnt_r <= (PTR_W+1)'(DEPTH - 2));
  assign out_res   = mem_r[rp_r];
  assign wp1       = wp_r + PTR_W'(1);

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push_n);
    rp_nxt  = rp_r + PTR_W'(pop);
    cnt_nxt = cnt_r + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wp_r] <= wr0;
    if (push_n == 2'd2) mem_r[wp1]  <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> space2)
    else $error("push into a queue without room for two");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W'(wp_r - rp_r) == cnt_r[PTR_W-1:0]))
    else $error("queue pointers disagree with fill count");

endmodule
